FILE: src/aswt_pkg.sv
// Package for the ARP binding watch table: constants, item and entry types,
// controller state type and a saturating increment helper.
// Depends on nothing; the top level, the checker and the testbench import it.
package aswt_pkg;

  // Table geometry.
  localparam int TABLE_DEPTH = 32;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Header values a frame must carry to be counted as ARP over Ethernet/IPv4.
  localparam logic [15:0] MIN_FRAME_LEN  = 16'd42;
  localparam logic [15:0] ETHERTYPE_ARP  = 16'h0806;
  localparam logic [15:0] HTYPE_ETHER    = 16'h0001;
  localparam logic [15:0] PTYPE_IPV4     = 16'h0800;
  localparam logic [7:0]  HLEN_ETHER     = 8'd6;
  localparam logic [7:0]  PLEN_IPV4      = 8'd4;
  localparam logic [15:0] OP_REQUEST     = 16'd1;
  localparam logic [15:0] OP_REPLY       = 16'd2;
  localparam logic [15:0] STORM_LIMIT_RESET = 16'd50;

  localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

  // Parsed header fields of one frame. The addresses use the usual ARP field
  // names: sender hardware address, sender and target protocol addresses.
  typedef struct packed {
    logic [15:0] frame_length;
    logic [15:0] ether_type;
    logic [15:0] hw_type;
    logic [15:0] proto_type;
    logic [7:0]  hw_addr_len;
    logic [7:0]  proto_addr_len;
    logic [15:0] arp_op;
    logic [47:0] sha;
    logic [31:0] spa;
    logic [31:0] tpa;
  } in_item_t;

  // One result per frame.
  typedef struct packed {
    logic        anomaly;
    logic        storm_active;
    logic [31:0] arp_seen;
    logic [31:0] spoof_total;
    logic [31:0] gratuitous_total;
    logic [5:0]  entries_used;
  } out_item_t;

  // One binding as stored in the table memory.
  typedef struct packed {
    logic [31:0] ip;
    logic [47:0] mac;
    logic        spoofed;
    logic        grat;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_UPDATE,
    S_FINISH
  } state_t;

  // Increment that holds at the all-ones value.
  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == SAT32) ? v : v + 32'd1;
  endfunction

endpackage

FILE: src/aswt_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing; contents are undefined until written.
module aswt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; data appears the cycle after the address.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/arp_spoof_watch_table_unit.sv
// Top level of the ARP binding watch table: frame check, table search and update.
// Depends on aswt_pkg and aswt_ram.
//
// Flow: a rejected frame or a zero sender goes straight from idle to the finish state; a
// lookup scans the used entries at one read per cycle from the table memory, then updates
// the entry (a full table with an unknown sender skips the update) before finishing.
// One frame at a time: busy drops in the cycle in which done shows the result, so the next
// transfer is taken at the earliest at the edge that ends it. The receiver cannot stall.
// Reset (rst, synchronous): table empty, counters and storm flag cleared, storm_limit 50.
module arp_spoof_watch_table_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  aswt_pkg::in_item_t  item,
  output logic              done,
  output aswt_pkg::out_item_t result,
  input  logic              cfg_we,
  input  logic [15:0]       cfg_wdata
);

  import aswt_pkg::*;

  state_t state, state_next;

  in_item_t          item_q;
  logic [15:0]       storm_limit;
  logic [CNT_W-1:0]  used_count;
  logic [31:0]       seen_count;
  logic [31:0]       spoof_count;
  logic [31:0]       grat_count;
  logic              storm_flag;
  logic              anom;

  // Scan pipeline: issue index, and the index whose data is on the read port.
  logic [CNT_W-1:0]  issue_idx;
  logic [IDX_W-1:0]  cmp_idx;
  logic              cmp_valid;

  // Entry under update and its slot.
  entry_t            hit_entry;
  logic [IDX_W-1:0]  slot;
  logic              fresh;

  // Memory port signals.
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  entry_t            ram_wdata;
  logic              ram_re;
  logic [IDX_W-1:0]  ram_raddr;
  entry_t            ram_rdata;
  logic [ENTRY_W-1:0] ram_rdata_raw;

  // Decoded conditions.
  logic accept;
  logic frame_ok;
  logic sip_zero;
  logic scan_hit;
  logic scan_miss;
  logic table_full;
  logic spoof_hit;
  logic grat_hit;
  logic storm_hit;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // Frame check on the incoming fields.
  assign frame_ok = (item.frame_length >= MIN_FRAME_LEN) &&
                    (item.ether_type == ETHERTYPE_ARP) &&
                    (item.hw_type == HTYPE_ETHER) &&
                    (item.proto_type == PTYPE_IPV4) &&
                    (item.hw_addr_len == HLEN_ETHER) &&
                    (item.proto_addr_len == PLEN_IPV4);
  assign sip_zero = (item.spa == 32'd0);

  // Search outcome: a match on returned data, or every used entry compared.
  assign ram_rdata  = entry_t'(ram_rdata_raw);
  assign scan_hit   = cmp_valid && (ram_rdata.ip == item_q.spa);
  assign scan_miss  = !cmp_valid && (issue_idx >= used_count);
  assign table_full = (used_count >= CNT_W'(TABLE_DEPTH));

  // Flag decisions for the entry under update.
  assign spoof_hit = !fresh && (hit_entry.mac != item_q.sha) && !hit_entry.spoofed;
  assign grat_hit  = (item_q.spa == item_q.tpa) &&
                     (item_q.arp_op inside {OP_REQUEST, OP_REPLY}) && !hit_entry.grat;
  assign storm_hit = (seen_count > {16'd0, storm_limit});

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (frame_ok && !sip_zero) ? S_SCAN : S_FINISH;
        end
      end
      S_SCAN: begin
        if (scan_hit) begin
          state_next = S_UPDATE;
        end else if (scan_miss) begin
          state_next = table_full ? S_FINISH : S_UPDATE;
        end
      end
      S_UPDATE: state_next = S_FINISH;
      S_FINISH: state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Memory controls.
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = issue_idx[IDX_W-1:0];
    ram_we    = 1'b0;
    ram_waddr = slot;
    ram_wdata = hit_entry;
    case (state)
      S_SCAN: begin
        ram_re = (issue_idx < used_count);
      end
      S_UPDATE: begin
        ram_we            = 1'b1;
        ram_wdata.spoofed = hit_entry.spoofed | spoof_hit;
        ram_wdata.grat    = hit_entry.grat | grat_hit;
      end
      default: begin
        ram_re = 1'b0;
      end
    endcase
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      storm_limit <= STORM_LIMIT_RESET;
    end else if (cfg_we) begin
      storm_limit <= cfg_wdata;
    end
  end

  // Controller and counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      used_count  <= '0;
      seen_count  <= '0;
      spoof_count <= '0;
      grat_count  <= '0;
      storm_flag  <= 1'b0;
      anom        <= 1'b0;
      issue_idx   <= '0;
      cmp_valid   <= 1'b0;
      done        <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == S_FINISH);
      case (state)
        S_IDLE: begin
          if (accept) begin
            anom      <= 1'b0;
            issue_idx <= '0;
            cmp_valid <= 1'b0;
            if (frame_ok) begin
              seen_count <= sat_inc(seen_count);
            end
          end
        end
        S_SCAN: begin
          cmp_valid <= ram_re;
          if (ram_re) begin
            issue_idx <= issue_idx + CNT_W'(1);
          end
        end
        S_UPDATE: begin
          if (fresh) begin
            used_count <= used_count + CNT_W'(1);
          end
          if (spoof_hit) begin
            spoof_count <= sat_inc(spoof_count);
          end
          if (grat_hit) begin
            grat_count <= sat_inc(grat_count);
          end
          if (storm_hit) begin
            storm_flag <= 1'b1;
          end
          anom <= spoof_hit || grat_hit || storm_hit;
        end
        default: begin
          anom <= anom;
        end
      endcase
    end
  end

  // Item capture, scan bookkeeping and the entry under update.
  always_ff @(posedge clk) begin
    if (accept) begin
      item_q <= item;
    end
    if (state == S_SCAN) begin
      cmp_idx <= issue_idx[IDX_W-1:0];
      if (scan_hit) begin
        hit_entry <= ram_rdata;
        slot      <= cmp_idx;
        fresh     <= 1'b0;
      end else if (scan_miss) begin
        hit_entry.ip      <= item_q.spa;
        hit_entry.mac     <= item_q.sha;
        hit_entry.spoofed <= 1'b0;
        hit_entry.grat    <= 1'b0;
        slot              <= used_count[IDX_W-1:0];
        fresh             <= 1'b1;
      end
    end
  end

  // Result register, loaded as the frame finishes.
  always_ff @(posedge clk) begin
    if (state == S_FINISH) begin
      result.anomaly          <= anom;
      result.storm_active     <= storm_flag;
      result.arp_seen         <= seen_count;
      result.spoof_total      <= spoof_count;
      result.gratuitous_total <= grat_count;
      result.entries_used     <= 6'(used_count);
    end
  end

  aswt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata_raw)
  );

endmodule

FILE: src/aswt_checker.sv
// Port-level checker for the ARP binding watch table, bound to the top level.
// Depends on aswt_pkg and arp_spoof_watch_table_unit.
module aswt_checker (
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic                busy,
  input logic                done,
  input aswt_pkg::out_item_t result
);

  import aswt_pkg::*;

  // An accepted transfer always makes the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("block did not go busy after an accepted transfer");

  // A result is shown only once the block is free again.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  // Results never come in consecutive cycles.
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for more than one cycle");

  // Reset drops the result strobe.
  a_reset_done: assert property (@(posedge clk)
    rst |=> !done)
    else $error("result strobe after reset");

  // The table never reports more entries than it holds.
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.entries_used <= 6'(TABLE_DEPTH)))
    else $error("entries_used beyond table depth");

endmodule

bind arp_spoof_watch_table_unit aswt_checker u_aswt_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .done      (done),
  .result    (result)
);

FILE: tb/sv/tb_arp_spoof_watch_table_unit.sv
// Self-checking testbench for arp_spoof_watch_table_unit: directed and random ARP header
// items, a per-frame binding-table predictor and a result checker. Depends on aswt_pkg
// and the arp_spoof_watch_table_unit RTL.
`timescale 1ns / 100ps

module tb_arp_spoof_watch_table_unit;
  import aswt_pkg::*;

  localparam int POOL_N = 40;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  item = '0;
  logic      done;
  out_item_t result;
  logic      cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;

  arp_spoof_watch_table_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Clock with a 2 ns period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Frames waiting to be sent and results still owed by the block.
  in_item_t  frame_q[$];
  out_item_t verdict_q[$];
  int        issued_n = 0;
  int        accepted_n = 0;
  int        fail_n = 0;
  bit        took = 1'b0;
  bit        calm = 1'b0;
  int        gap_left = 0;

  // Predictor copy of the binding table, counters and storm register.
  logic [31:0] ip_m [TABLE_DEPTH];
  logic [47:0] mac_m [TABLE_DEPTH];
  bit          spoofed_m [TABLE_DEPTH];
  bit          grat_m [TABLE_DEPTH];
  int          used_m;
  logic [31:0] seen_m, spoof_m, grat_cnt_m;
  bit          storm_m;
  logic [15:0] limit_m;

  // Address pools so that most random frames hit bindings already in the table.
  logic [31:0] ip_pool [POOL_N];
  logic [47:0] mac_pool [POOL_N][2];

  // Work out the result of one frame and update the predicted table state.
  function automatic out_item_t predict_watch(input in_item_t f);
    out_item_t r;
    int        slot;
    bit        fresh;
    bit        flag;
    slot  = -1;
    fresh = 1'b0;
    flag  = 1'b0;
    if (f.frame_length >= MIN_FRAME_LEN && f.ether_type == ETHERTYPE_ARP &&
        f.hw_type == HTYPE_ETHER && f.proto_type == PTYPE_IPV4 &&
        f.hw_addr_len == HLEN_ETHER && f.proto_addr_len == PLEN_IPV4) begin
      if (seen_m != SAT32) seen_m = seen_m + 32'd1;
      if (f.spa != '0) begin
        for (int k = 0; k < used_m; k++) begin
          if (slot < 0 && ip_m[k] == f.spa) slot = k;
        end
        // Append an unknown sender while the table has room.
        if (slot < 0 && used_m < TABLE_DEPTH) begin
          slot = used_m;
          ip_m[slot]      = f.spa;
          mac_m[slot]     = f.sha;
          spoofed_m[slot] = 1'b0;
          grat_m[slot]    = 1'b0;
          used_m++;
          fresh = 1'b1;
        end
        // A full table with an unknown sender ends here, without the storm check.
        if (slot >= 0) begin
          if (!fresh && mac_m[slot] != f.sha && !spoofed_m[slot]) begin
            spoofed_m[slot] = 1'b1;
            if (spoof_m != SAT32) spoof_m = spoof_m + 32'd1;
            flag = 1'b1;
          end
          if (f.spa == f.tpa && (f.arp_op == OP_REQUEST || f.arp_op == OP_REPLY) &&
              !grat_m[slot]) begin
            grat_m[slot] = 1'b1;
            if (grat_cnt_m != SAT32) grat_cnt_m = grat_cnt_m + 32'd1;
            flag = 1'b1;
          end
          if (seen_m > {16'h0, limit_m}) begin
            storm_m = 1'b1;
            flag    = 1'b1;
          end
        end
      end
    end
    r.anomaly          = flag;
    r.storm_active     = storm_m;
    r.arp_seen         = seen_m;
    r.spoof_total      = spoof_m;
    r.gratuitous_total = grat_cnt_m;
    r.entries_used     = 6'(used_m);
    return r;
  endfunction

  // Field-by-field comparison of one result with its expectation.
  task automatic compare_verdict(input out_item_t got, input out_item_t want);
    if (got.anomaly !== want.anomaly) begin
      $error("anomaly: expected %0h actual %0h", want.anomaly, got.anomaly);
      fail_n++;
    end
    if (got.storm_active !== want.storm_active) begin
      $error("storm_active: expected %0h actual %0h", want.storm_active, got.storm_active);
      fail_n++;
    end
    if (got.arp_seen !== want.arp_seen) begin
      $error("arp_seen: expected %0h actual %0h", want.arp_seen, got.arp_seen);
      fail_n++;
    end
    if (got.spoof_total !== want.spoof_total) begin
      $error("spoof_total: expected %0h actual %0h", want.spoof_total, got.spoof_total);
      fail_n++;
    end
    if (got.gratuitous_total !== want.gratuitous_total) begin
      $error("gratuitous_total: expected %0h actual %0h", want.gratuitous_total,
             got.gratuitous_total);
      fail_n++;
    end
    if (got.entries_used !== want.entries_used) begin
      $error("entries_used: expected %0h actual %0h", want.entries_used, got.entries_used);
      fail_n++;
    end
  endtask

  // Monitor: check each result, then predict any frame transferred at this edge.
  always @(posedge clk) begin
    if (rst) begin
      used_m     = 0;
      seen_m     = '0;
      spoof_m    = '0;
      grat_cnt_m = '0;
      storm_m    = 1'b0;
      limit_m    = STORM_LIMIT_RESET;
      took <= 1'b0;
    end else begin
      if (cfg_we) limit_m = cfg_wdata;
      if (done) begin
        if (verdict_q.size() == 0) begin
          $error("result with no frame outstanding");
          fail_n++;
        end else begin
          compare_verdict(result, verdict_q.pop_front());
        end
      end
      if (start && !busy) begin
        verdict_q.push_back(predict_watch(item));
        accepted_n++;
        took <= 1'b1;
      end else begin
        took <= 1'b0;
      end
    end
  end

  // Driver: hold each frame until it is transferred, with random idle bursts between until calm is set.
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && !took) begin
      start <= 1'b1;
    end else if (took && !calm && $urandom_range(0, 2) == 0) begin
      start    <= 1'b0;
      gap_left <= $urandom_range(1, 14);
    end else if (gap_left > 0) begin
      start    <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (frame_q.size() > 0) begin
      item  <= frame_q.pop_front();
      start <= 1'b1;
    end else begin
      start <= 1'b0;
    end
  end

  // Well-formed Ethernet/IPv4 ARP header with the given content.
  function automatic in_item_t arp_frame(input logic [15:0] len, input logic [15:0] op,
                                         input logic [47:0] mac, input logic [31:0] sip,
                                         input logic [31:0] tip);
    in_item_t f;
    f.frame_length   = len;
    f.ether_type     = ETHERTYPE_ARP;
    f.hw_type        = HTYPE_ETHER;
    f.proto_type     = PTYPE_IPV4;
    f.hw_addr_len    = HLEN_ETHER;
    f.proto_addr_len = PLEN_IPV4;
    f.arp_op         = op;
    f.sha            = mac;
    f.spa            = sip;
    f.tpa            = tip;
    return f;
  endfunction

  function automatic logic [47:0] rand_mac();
    return {16'($urandom()), 32'($urandom())};
  endfunction

  // Mostly well-formed frames on pooled addresses, plus noise and single-field damage.
  function automatic in_item_t random_frame();
    in_item_t    f;
    int          pick;
    int          k;
    logic [15:0] len;
    logic [15:0] op;
    logic [47:0] mac;
    logic [31:0] sip;
    logic [31:0] tip;
    pick = $urandom_range(0, 99);
    k    = $urandom_range(0, POOL_N - 1);
    case ($urandom_range(0, 9))
      0:       len = MIN_FRAME_LEN;
      1:       len = 16'hFFFF;
      2:       len = 16'($urandom_range(42, 65535));
      default: len = 16'($urandom_range(42, 1518));
    endcase
    case ($urandom_range(0, 19))
      0, 1, 2: op = 16'($urandom());
      3, 4, 5, 6, 7, 8, 9, 10: op = OP_REPLY;
      default: op = OP_REQUEST;
    endcase
    if (pick < 20) begin
      sip = $urandom();
      mac = rand_mac();
    end else if (pick < 25) begin
      sip = '0;
      mac = rand_mac();
    end else begin
      sip = ip_pool[k];
      mac = ($urandom_range(0, 6) == 0) ? rand_mac() : mac_pool[k][$urandom_range(0, 1)];
    end
    case ($urandom_range(0, 9))
      0, 1, 2: tip = sip;
      3, 4:    tip = ip_pool[$urandom_range(0, POOL_N - 1)];
      default: tip = $urandom();
    endcase
    f = arp_frame(len, op, mac, sip, tip);
    if (pick >= 92) begin
      // Random noise in every header check field.
      f.frame_length   = 16'($urandom());
      f.ether_type     = 16'($urandom());
      f.hw_type        = 16'($urandom());
      f.proto_type     = 16'($urandom());
      f.hw_addr_len    = 8'($urandom());
      f.proto_addr_len = 8'($urandom());
    end else if (pick >= 85) begin
      // Break exactly one of the header checks.
      case ($urandom_range(0, 5))
        0: f.frame_length   = 16'($urandom_range(0, 41));
        1: f.ether_type     = ETHERTYPE_ARP ^ 16'($urandom_range(1, 65535));
        2: f.hw_type        = HTYPE_ETHER ^ 16'($urandom_range(1, 65535));
        3: f.proto_type     = PTYPE_IPV4 ^ 16'($urandom_range(1, 65535));
        4: f.hw_addr_len    = HLEN_ETHER ^ 8'($urandom_range(1, 255));
        default: f.proto_addr_len = PLEN_IPV4 ^ 8'($urandom_range(1, 255));
      endcase
    end
    return f;
  endfunction

  task automatic queue_frame(input in_item_t f);
    frame_q.push_back(f);
    issued_n++;
  endtask

  task automatic queue_random(input int n);
    repeat (n) queue_frame(random_frame());
  endtask

  // Wait until every frame is transferred and every result has come back.
  task automatic wait_drained();
    while (!(accepted_n == issued_n && verdict_q.size() == 0)) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Storm limit write, only with the block idle.
  task automatic write_limit(input logic [15:0] v);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  // Stimulus and end of run.
  initial begin
    in_item_t f;
    for (int k = 0; k < POOL_N; k++) begin
      ip_pool[k] = $urandom();
      if (ip_pool[k] == '0) ip_pool[k] = 32'h1;
      mac_pool[k][0] = rand_mac();
      mac_pool[k][1] = rand_mac();
    end
    ip_pool[0] = 32'hFFFF_FFFF;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part: each header check failing, zero sender, binding life cycle.
    f = arp_frame(16'd41, OP_REQUEST, 48'h0200_0000_0001, 32'hC0A8_0001, 32'hC0A8_00FE);
    queue_frame(f);
    f.frame_length = '0;
    queue_frame(f);
    f = arp_frame(16'd60, OP_REQUEST, 48'h0200_0000_0001, 32'hC0A8_0001, 32'hC0A8_00FE);
    f.ether_type = PTYPE_IPV4;
    queue_frame(f);
    f.ether_type = ETHERTYPE_ARP;
    f.hw_type = 16'd6;
    queue_frame(f);
    f.hw_type = HTYPE_ETHER;
    f.proto_type = 16'h86DD;
    queue_frame(f);
    f.proto_type = PTYPE_IPV4;
    f.hw_addr_len = 8'hFF;
    queue_frame(f);
    f.hw_addr_len = HLEN_ETHER;
    f.proto_addr_len = 8'd16;
    queue_frame(f);
    queue_frame('0);
    queue_frame('1);
    // Zero sender is counted but leaves the table alone.
    queue_frame(arp_frame(MIN_FRAME_LEN, OP_REQUEST, 48'h0200_0000_0009, '0, '0));
    // New binding, repeat with the same MAC, then two conflicting MACs.
    queue_frame(arp_frame(MIN_FRAME_LEN, OP_REQUEST, 48'h0200_0000_00AA, 32'hC0A8_0001,
                          32'hC0A8_00FE));
    queue_frame(arp_frame(16'hFFFF, OP_REPLY, 48'h0200_0000_00AA, 32'hC0A8_0001,
                          32'hC0A8_00FE));
    queue_frame(arp_frame(16'd60, OP_REPLY, 48'h0200_0000_00BB, 32'hC0A8_0001,
                          32'hC0A8_00FE));
    queue_frame(arp_frame(16'd60, OP_REQUEST, 48'h0200_0000_00CC, 32'hC0A8_0001,
                          32'hC0A8_00FE));
    // Gratuitous request on an existing binding, flagged only once.
    queue_frame(arp_frame(16'd60, OP_REQUEST, 48'h0200_0000_00AA, 32'hC0A8_0001,
                          32'hC0A8_0001));
    queue_frame(arp_frame(16'd60, OP_REQUEST, 48'h0200_0000_00AA, 32'hC0A8_0001,
                          32'hC0A8_0001));
    // Gratuitous reply on a fresh binding with all-ones addresses.
    queue_frame(arp_frame(16'd64, OP_REPLY, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF,
                          32'hFFFF_FFFF));
    // Other opcodes are tracked but never gratuitous.
    queue_frame(arp_frame(16'd64, 16'd3, 48'h0200_0000_0101, 32'h0A00_0001, 32'h0A00_0001));
    queue_frame(arp_frame(16'd64, 16'd0, 48'h0200_0000_0101, 32'h0A00_0001, 32'h0A00_0001));
    queue_frame(arp_frame(16'd64, 16'hFFFF, 48'h0200_0000_0101, 32'h0A00_0001,
                          32'h0A00_0001));
    queue_frame(arp_frame(16'd42, OP_REQUEST, '0, 32'h0000_0001, '0));

    // Random phases across storm limit settings; the table fills up along the way.
    queue_random(130);
    write_limit(16'hFFFF);
    queue_random(90);
    write_limit(16'h0000);
    queue_random(50);
    write_limit(16'($urandom_range(150, 450)));
    calm = 1'b1;
    queue_random(110);

    wait_drained();
    repeat (40) @(posedge clk);
    if (fail_n == 0) begin
      $display("tb_arp_spoof_watch_table_unit OK");
    end else begin
      $display("tb_arp_spoof_watch_table_unit NOT OK");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #500000;
    $display("tb_arp_spoof_watch_table_unit NOT OK");
    $finish;
  end

endmodule

FILE: files.f
src/aswt_pkg.sv
src/aswt_ram.sv
src/arp_spoof_watch_table_unit.sv
src/aswt_checker.sv
tb/sv/tb_arp_spoof_watch_table_unit.sv
